/* sv/aat_pkg.sv */
package aat_pkg;

    localparam int COORD_W   = 16;
    localparam int COEF_W    = 16;
    localparam int COEF_FRAC = 12;
    localparam int TRANS_SH  = 8;
    localparam int NUM_AXES  = 3;
    localparam int PROD_W    = COORD_W + COEF_W;
    localparam int ACC_W     = PROD_W + 4;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int RAD_W     = COORD_W + 1;
    localparam int ROW_W     = 4 * COEF_W;
    // lane stages, sum stage, square-root steps
    localparam int LANE_STAGES = 3;
    localparam int PIPE_STAGES = LANE_STAGES + 1 + SQRT_STEPS;

    typedef enum logic [1:0] {
        CFG_ROW_X = 2'd0,
        CFG_ROW_Y = 2'd1,
        CFG_ROW_Z = 2'd2
    } t_cfg_idx;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord min_x;
        t_coord min_y;
        t_coord min_z;
        t_coord max_x;
        t_coord max_y;
        t_coord max_z;
    } t_in;

    typedef struct packed {
        t_coord              out_min_x;
        t_coord              out_min_y;
        t_coord              out_min_z;
        t_coord              out_max_x;
        t_coord              out_max_y;
        t_coord              out_max_z;
        t_coord              center_x;
        t_coord              center_y;
        t_coord              center_z;
        logic [RAD_W-1:0]    radius;
    } t_out;

    typedef struct packed {
        logic prod;
        logic corner;
        logic square;
    } t_lane_en;

endpackage

/* sv/aat_lane.sv */
module aat_lane (
    input  logic                       i_clk,
    input  aat_pkg::t_lane_en          i_en,
    input  logic [aat_pkg::ROW_W-1:0]  i_row,
    input  aat_pkg::t_coord            i_lo [aat_pkg::NUM_AXES],
    input  aat_pkg::t_coord            i_hi [aat_pkg::NUM_AXES],
    output aat_pkg::t_coord            o_min,
    output aat_pkg::t_coord            o_max,
    output aat_pkg::t_coord            o_ctr,
    output logic [aat_pkg::SQ_W-1:0]   o_sq
);
    import aat_pkg::*;

    logic signed [PROD_W-1:0] r_pmin [NUM_AXES];
    logic signed [PROD_W-1:0] r_pmax [NUM_AXES];
    logic signed [PROD_W-1:0] n_pmin [NUM_AXES];
    logic signed [PROD_W-1:0] n_pmax [NUM_AXES];
    logic signed [ACC_W-1:0]  r_trans;
    logic signed [ACC_W-1:0]  n_trans;
    t_coord                   r_min, r_max, n_min, n_max;
    t_coord                   r_ctr, n_ctr;
    logic [SQ_W-1:0]          r_sq, n_sq;
    logic signed [ACC_W-1:0]  acc_min, acc_max;
    logic signed [ACC_W-COEF_FRAC-1:0] sh_min, sh_max;
    logic signed [COORD_W:0]  pair_sum, half_span;
    logic [COORD_W-1:0]       half_span_u;

    function automatic t_coord sat(input logic signed [ACC_W-COEF_FRAC-1:0] v);
        logic signed [ACC_W-COEF_FRAC-1:0] hi, lo;
        hi = (ACC_W-COEF_FRAC)'(2**(COORD_W-1) - 1);
        lo = -hi - 1;
        if (v > hi) begin
            sat = hi[COORD_W-1:0];
        end else if (v < lo) begin
            sat = lo[COORD_W-1:0];
        end else begin
            sat = v[COORD_W-1:0];
        end
    endfunction

    always_comb begin
        for (int j = 0; j < NUM_AXES; j++) begin
            logic signed [COEF_W-1:0] c;
            logic signed [PROD_W-1:0] a, b;
            c = i_row[COEF_W*j +: COEF_W];
            a = i_lo[j] * c;
            b = i_hi[j] * c;
            n_pmin[j] = (a < b) ? a : b;
            n_pmax[j] = (a < b) ? b : a;
        end
        n_trans = ACC_W'($signed(i_row[ROW_W-1 -: COEF_W])) <<< TRANS_SH;
    end

    always_comb begin
        acc_min = r_trans;
        acc_max = r_trans;
        for (int j = 0; j < NUM_AXES; j++) begin
            acc_min = acc_min + ACC_W'(r_pmin[j]);
            acc_max = acc_max + ACC_W'(r_pmax[j]);
        end
        sh_min = acc_min[ACC_W-1:COEF_FRAC];
        sh_max = acc_max[ACC_W-1:COEF_FRAC];
        n_min  = sat(sh_min);
        n_max  = sat(sh_max);
    end

    always_comb begin
        pair_sum    = (COORD_W+1)'(r_min) + (COORD_W+1)'(r_max);
        n_ctr       = pair_sum[COORD_W:1];
        half_span   = (COORD_W+1)'(r_max) - (COORD_W+1)'(n_ctr);
        // corners are ordered, so the distance is never negative
        half_span_u = half_span[COORD_W-1:0];
        n_sq        = half_span_u * half_span_u;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.prod) begin
            r_pmin  <= n_pmin;
            r_pmax  <= n_pmax;
            r_trans <= n_trans;
        end
        if (i_en.corner) begin
            r_min <= n_min;
            r_max <= n_max;
        end
        if (i_en.square) begin
            o_min <= r_min;
            o_max <= r_max;
            r_ctr <= n_ctr;
            r_sq  <= n_sq;
        end
    end

    assign o_ctr = r_ctr;
    assign o_sq  = r_sq;

endmodule

/* sv/aat_merge.sv */
module aat_merge (
    input  logic                          i_clk,
    input  logic [aat_pkg::SQRT_STEPS:0]  i_en,
    input  aat_pkg::t_coord               i_min [aat_pkg::NUM_AXES],
    input  aat_pkg::t_coord               i_max [aat_pkg::NUM_AXES],
    input  aat_pkg::t_coord               i_ctr [aat_pkg::NUM_AXES],
    input  logic [aat_pkg::SQ_W-1:0]      i_sq  [aat_pkg::NUM_AXES],
    output aat_pkg::t_out                 o_out
);
    import aat_pkg::*;

    logic [SQ_W-1:0] r_rem [SQRT_STEPS+1];
    logic [SQ_W-1:0] r_res [SQRT_STEPS+1];
    t_out            r_pay [SQRT_STEPS+1];
    logic [SQ_W-1:0] n_sum;
    t_out            n_pay;

    always_comb begin
        n_sum = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            n_sum = n_sum + i_sq[a];
        end
        n_pay = '{out_min_x: i_min[0], out_min_y: i_min[1], out_min_z: i_min[2],
                  out_max_x: i_max[0], out_max_y: i_max[1], out_max_z: i_max[2],
                  center_x: i_ctr[0], center_y: i_ctr[1], center_z: i_ctr[2],
                  radius: '0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= n_sum;
            r_res[0] <= '0;
            r_pay[0] <= n_pay;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
        logic [SQ_W-1:0] trial, n_rem, n_res;

        always_comb begin
            trial = r_res[k] + BIT;
            if (r_rem[k] >= trial) begin
                n_rem = r_rem[k] - trial;
                n_res = (r_res[k] >> 1) + BIT;
            end else begin
                n_rem = r_rem[k];
                n_res = r_res[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k+1]) begin
                r_rem[k+1] <= n_rem;
                r_res[k+1] <= n_res;
                r_pay[k+1] <= r_pay[k];
            end
        end
    end

    always_comb begin
        o_out        = r_pay[SQRT_STEPS];
        o_out.radius = r_res[SQRT_STEPS][RAD_W-1:0];
    end

endmodule

/* sv/aabb_affine_transform.sv */
// channel | direction | handshake            | payload
// in      | to block  | i_valid / o_stall    | i_in  (t_in)
// out     | from block| o_valid / i_stall    | o_out (t_out)
// cfg     | to block  | i_cfg_we             | i_cfg_idx, i_cfg_wdata
// One box per cycle while the output is not stalled; 3 lane stages, one sum
// stage and 16 square-root steps, one result bit per step.
// Each stage holds only while its successor is full and held, so bubbles
// close up under an output stall and the input stalls only when all is full.
// Reset is synchronous, active low; it clears the valid bits and the rows.
module aabb_affine_transform (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  aat_pkg::t_in                i_in,
    output logic                        o_valid,
    input  logic                        i_stall,
    output aat_pkg::t_out               o_out,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [aat_pkg::ROW_W-1:0]   i_cfg_wdata
);
    import aat_pkg::*;

    logic [ROW_W-1:0]       r_row [NUM_AXES];
    logic [PIPE_STAGES-1:0] r_vld, n_vld;
    logic [PIPE_STAGES-1:0] en;
    t_coord                 lo [NUM_AXES];
    t_coord                 hi [NUM_AXES];
    t_coord                 l_min [NUM_AXES];
    t_coord                 l_max [NUM_AXES];
    t_coord                 l_ctr [NUM_AXES];
    logic [SQ_W-1:0]        l_sq  [NUM_AXES];
    t_lane_en               lane_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_row[a] <= '0;
            end
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ROW_X: r_row[0] <= i_cfg_wdata;
                CFG_ROW_Y: r_row[1] <= i_cfg_wdata;
                CFG_ROW_Z: r_row[2] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // en[k] loads stage k; the last stage is the output register
    always_comb begin
        en[PIPE_STAGES-1] = !r_vld[PIPE_STAGES-1] || !i_stall;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        n_vld = r_vld;
        if (en[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k < PIPE_STAGES; k++) begin
            if (en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[PIPE_STAGES-1];

    assign lo = '{i_in.min_x, i_in.min_y, i_in.min_z};
    assign hi = '{i_in.max_x, i_in.max_y, i_in.max_z};
    assign lane_en = '{prod: en[0], corner: en[1], square: en[2]};

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
        aat_lane u_lane (
            .i_clk (i_clk),
            .i_en  (lane_en),
            .i_row (r_row[a]),
            .i_lo  (lo),
            .i_hi  (hi),
            .o_min (l_min[a]),
            .o_max (l_max[a]),
            .o_ctr (l_ctr[a]),
            .o_sq  (l_sq[a])
        );
    end

    aat_merge u_merge (
        .i_clk (i_clk),
        .i_en  (en[PIPE_STAGES-1:LANE_STAGES]),
        .i_min (l_min),
        .i_max (l_max),
        .i_ctr (l_ctr),
        .i_sq  (l_sq),
        .o_out (o_out)
    );

`ifndef NO_ASSERTIONS
    a_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.out_min_x <= o_out.out_max_x) &&
                    (o_out.out_min_y <= o_out.out_max_y) &&
                    (o_out.out_min_z <= o_out.out_max_z))
        else $error("transformed corners out of order");
    a_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.center_x >= o_out.out_min_x) &&
                    (o_out.center_x <= o_out.out_max_x))
        else $error("center outside the box");
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall && (r_vld == '1)))
        else $error("input stalled with room in the pipeline");
`endif

endmodule
